// ===== rtl/mpkst_pkg.sv =====
package mpkst_pkg;

  localparam int MAX_SOURCES = 16;
  localparam int TIMEOUT_MS  = 2000;
  localparam int SLOT_W      = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

  localparam logic [31:0] TIMEOUT_FULL = 32'(TIMEOUT_MS);
  localparam logic [31:0] TIMEOUT_HALF = 32'(TIMEOUT_MS / 2);

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_WHEEL  = 2'd1;
  localparam logic [1:0] ACT_POWER  = 2'd2;
  localparam logic [1:0] ACT_STATUS = 2'd3;

  localparam logic [1:0] KEY_OFF    = 2'd0;
  localparam logic [1:0] KEY_NOTOFF = 2'd1;
  localparam logic [1:0] KEY_ERROR  = 2'd2;

  localparam logic [2:0] KIND_FRAME     = 3'd0;
  localparam logic [2:0] KIND_KEY_OFF   = 3'd1;
  localparam logic [2:0] KIND_UPDATE    = 3'd2;
  localparam logic [2:0] KIND_MALFORMED = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  localparam logic [2:0] REG_MAINTAIN = 3'd0;
  localparam logic [2:0] REG_SENDER   = 3'd1;
  localparam logic [2:0] REG_ACT_PWR  = 3'd2;
  localparam logic [2:0] REG_ECU_PWR  = 3'd3;
  localparam logic [2:0] REG_IN_WORK  = 3'd4;
  localparam logic [2:0] REG_READY    = 3'd5;
  localparam logic [2:0] REG_PARK     = 3'd6;
  localparam logic [2:0] REG_TRANSP   = 3'd7;

  localparam logic [3:0] FRAME_LEN = 4'd8;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] data_length;
    logic       source_valid;
    logic [7:0] source_id;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_seven;
    logic       tx_ok;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] frame_byte_zero;
    logic [7:0] frame_byte_one;
    logic [7:0] entry_source;
    logic [3:0] entry_slot;
    logic       changed;
    logic       last;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic emit;
    logic emit_sel;
  } cmd_t;

  typedef struct packed {
    logic       scan_last;
    logic [1:0] res_now;
    logic [1:0] res_count;
  } sts_t;

endpackage

// ===== rtl/maintain_power_key_switch_tracker.sv =====
// An accepted transaction walks the source table in the scan state, one entry per step
// over all MAX_SOURCES entries, then passes the commit state and one emit state per
// result, of which there are at most two. A new transaction is taken only in idle, so
// the next one cannot start before the last one is through; busy is high meanwhile.
// Results are shown on out_result for exactly one cycle under out_valid; the receiver
// cannot stall. Synchronous active-low reset clears the timers, valid flags, table use
// bits and configuration to their reset values; no clearing pass is needed.
module maintain_power_key_switch_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mpkst_pkg::in_t   in_item,
  output logic             out_valid,
  output mpkst_pkg::out_t  out_result,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  // The controller sequences each transaction; the datapath holds the table, timers and configuration.
  mpkst_pkg::cmd_t cmd;
  mpkst_pkg::sts_t sts;

  mpkst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath walks the table one entry per cycle, expiring stale sources on
  // ticks and locating the sender's entry or the first free slot on frames.
  mpkst_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_result (out_result)
  );

  // Each emit cycle presents exactly one result.
  assign out_valid = cmd.emit;

endmodule

// ===== rtl/mpkst_ctrl.sv =====
module mpkst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mpkst_pkg::sts_t   sts,
  output mpkst_pkg::cmd_t   cmd,
  output logic              busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_COMMIT = 3'd2;
  localparam logic [2:0] S_EMIT0  = 3'd3;
  localparam logic [2:0] S_EMIT1  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = (sts.res_now == 2'd0) ? S_IDLE : S_EMIT0;
      end
      S_EMIT0: begin
        cmd.emit  = 1'b1;
        state_nxt = (sts.res_count == 2'd2) ? S_EMIT1 : S_IDLE;
      end
      S_EMIT1: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

  a_emit1_after_emit0: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT1) |-> ($past(state_r) == S_EMIT0))
    else $error("second result without a first");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_SCAN))
    else $error("accepted transaction did not start a scan");
  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !sts.scan_last) |=> (state_r == S_SCAN))
    else $error("scan left early");

endmodule

// ===== rtl/mpkst_dp.sv =====
module mpkst_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mpkst_pkg::in_t    in_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  mpkst_pkg::cmd_t   cmd,
  output mpkst_pkg::sts_t   sts,
  output mpkst_pkg::out_t   out_result
);

  localparam int SW = mpkst_pkg::SLOT_W;

  logic [31:0] maintain_r;
  logic        sender_r;
  logic [1:0]  act_pwr_r, ecu_pwr_r, in_work_r, ready_r, park_r, transp_r;

  mpkst_pkg::in_t item_r;
  logic [31:0] now_r, key_off_time_r, last_send_r;
  logic        key_off_v_r, key_on_v_r, last_send_v_r;

  logic [mpkst_pkg::MAX_SOURCES-1:0] used_r;
  logic [7:0]  addr_r  [mpkst_pkg::MAX_SOURCES];
  logic [11:0] field_r [mpkst_pkg::MAX_SOURCES];
  logic [31:0] stamp_r [mpkst_pkg::MAX_SOURCES];

  logic [SW-1:0] idx_r, hit_slot_r, free_slot_r;
  logic          hit_r, free_r;

  mpkst_pkg::out_t res0_r, res1_r, r0, r1;
  logic [1:0]      cnt_r, n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maintain_r <= '0;
      sender_r   <= 1'b0;
      act_pwr_r  <= 2'd3;
      ecu_pwr_r  <= 2'd3;
      in_work_r  <= 2'd3;
      ready_r    <= 2'd3;
      park_r     <= 2'd3;
      transp_r   <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        mpkst_pkg::REG_MAINTAIN: maintain_r <= cfg_data;
        mpkst_pkg::REG_SENDER:   sender_r   <= cfg_data[0];
        mpkst_pkg::REG_ACT_PWR:  act_pwr_r  <= cfg_data[1:0];
        mpkst_pkg::REG_ECU_PWR:  ecu_pwr_r  <= cfg_data[1:0];
        mpkst_pkg::REG_IN_WORK:  in_work_r  <= cfg_data[1:0];
        mpkst_pkg::REG_READY:    ready_r    <= cfg_data[1:0];
        mpkst_pkg::REG_PARK:     park_r     <= cfg_data[1:0];
        mpkst_pkg::REG_TRANSP:   transp_r   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  logic       is_tick, is_frame_ok, is_wheel, is_power, resend;
  logic [1:0] key;
  logic [SW-1:0] slot_sel;
  logic [SW+3:0] slot_ext;
  logic [11:0] f_new, f_old;
  mpkst_pkg::out_t frame, blank;

  assign is_tick     = (item_r.action == mpkst_pkg::ACT_TICK);
  assign is_frame_ok = (item_r.data_length == mpkst_pkg::FRAME_LEN) && item_r.source_valid;
  assign is_wheel    = is_frame_ok && (item_r.action == mpkst_pkg::ACT_WHEEL);
  assign is_power    = is_frame_ok && (item_r.action == mpkst_pkg::ACT_POWER);
  assign key         = item_r.byte_seven[3:2];
  assign resend      = last_send_v_r && key_off_v_r && sender_r &&
                       ((now_r - last_send_r) >= mpkst_pkg::TIMEOUT_HALF) &&
                       ((now_r - key_off_time_r) < maintain_r);
  assign slot_sel    = hit_r ? hit_slot_r : free_slot_r;
  assign slot_ext    = {4'b0000, slot_sel};
  assign f_new       = {item_r.byte_one, item_r.byte_zero[7:4]};
  assign f_old       = hit_r ? field_r[slot_sel] : 12'hFFF;

  always_comb begin
    blank = '0;
    frame = '0;
    frame.kind            = mpkst_pkg::KIND_FRAME;
    frame.frame_byte_zero = {ecu_pwr_r, act_pwr_r, 4'hF};
    frame.frame_byte_one  = {transp_r, park_r, ready_r, in_work_r};
    r0 = blank;
    r1 = blank;
    n  = 2'd0;
    case (item_r.action)
      mpkst_pkg::ACT_TICK: begin
        if (resend) begin
          r0 = frame;
          n  = 2'd1;
        end
      end
      mpkst_pkg::ACT_STATUS: begin
        if (!item_r.tx_ok && sender_r) begin
          r0 = frame;
          n  = 2'd1;
        end
      end
      default: begin
        if (item_r.data_length != mpkst_pkg::FRAME_LEN) begin
          r0.kind = mpkst_pkg::KIND_MALFORMED;
          n       = 2'd1;
        end else if (is_wheel) begin
          if (key == mpkst_pkg::KEY_OFF && key_on_v_r) begin
            if (sender_r) begin
              r0      = frame;
              r1.kind = mpkst_pkg::KIND_KEY_OFF;
              n       = 2'd2;
            end else begin
              r0.kind = mpkst_pkg::KIND_KEY_OFF;
              n       = 2'd1;
            end
          end
        end else if (is_power) begin
          n = 2'd1;
          if (!hit_r && !free_r) begin
            r0.kind = mpkst_pkg::KIND_FULL;
          end else begin
            r0.kind            = mpkst_pkg::KIND_UPDATE;
            r0.frame_byte_zero = {f_new[3:0], 4'hF};
            r0.frame_byte_one  = f_new[11:4];
            r0.entry_source    = item_r.source_id;
            r0.entry_slot      = slot_ext[3:0];
            r0.changed         = (f_old != f_new);
          end
        end
      end
    endcase
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r          <= '0;
      key_off_time_r <= '0;
      last_send_r    <= '0;
      key_off_v_r    <= 1'b0;
      key_on_v_r     <= 1'b0;
      last_send_v_r  <= 1'b0;
      used_r         <= '0;
      idx_r          <= '0;
      hit_r          <= 1'b0;
      free_r         <= 1'b0;
      cnt_r          <= '0;
    end else begin
      if (cmd.load) begin
        idx_r  <= '0;
        hit_r  <= 1'b0;
        free_r <= 1'b0;
        if (in_item.action == mpkst_pkg::ACT_TICK) now_r <= now_r + 32'd1;
      end
      if (cmd.step) begin
        idx_r <= idx_r + SW'(1);
        if (is_tick && used_r[idx_r] &&
            ((now_r - stamp_r[idx_r]) >= mpkst_pkg::TIMEOUT_FULL)) begin
          used_r[idx_r] <= 1'b0;
        end
        if (used_r[idx_r]) begin
          if (!hit_r && addr_r[idx_r] == item_r.source_id) begin
            hit_r      <= 1'b1;
            hit_slot_r <= idx_r;
          end
        end else if (!free_r) begin
          free_r      <= 1'b1;
          free_slot_r <= idx_r;
        end
      end
      if (cmd.commit) begin
        cnt_r  <= n;
        res0_r <= r0;
        res1_r <= r1;
        if (is_tick && resend) last_send_r <= now_r;
        if (is_wheel) begin
          case (key)
            mpkst_pkg::KEY_OFF: begin
              if (key_on_v_r) begin
                key_on_v_r     <= 1'b0;
                key_off_time_r <= now_r;
                key_off_v_r    <= 1'b1;
                last_send_r    <= now_r;
                last_send_v_r  <= 1'b1;
              end else if (!key_off_v_r) begin
                key_off_time_r <= now_r;
                key_off_v_r    <= 1'b1;
              end
            end
            mpkst_pkg::KEY_NOTOFF: begin
              key_off_v_r   <= 1'b0;
              key_on_v_r    <= 1'b1;
              last_send_v_r <= 1'b0;
            end
            mpkst_pkg::KEY_ERROR: begin
              key_off_v_r   <= 1'b0;
              key_on_v_r    <= 1'b0;
              last_send_v_r <= 1'b0;
            end
            default: ;
          endcase
        end
        if (is_power && (hit_r || free_r)) used_r[slot_sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.commit && is_power && (hit_r || free_r)) begin
      addr_r[slot_sel]  <= item_r.source_id;
      field_r[slot_sel] <= f_new;
      stamp_r[slot_sel] <= now_r;
    end
  end

  assign sts.scan_last = (idx_r == SW'(mpkst_pkg::MAX_SOURCES - 1));
  assign sts.res_now   = n;
  assign sts.res_count = cnt_r;
  assign out_result    = cmd.emit_sel ? res1_r : res0_r;

endmodule
